>>> design/cpt_pkg.sv
// Shared constants, arctangent table and saturation helper of the half-cosine motion profile generator.
`default_nettype none
package cpt_pkg;

  typedef enum logic [1:0] {
    REG_START_POSITION = 2'd0,
    REG_END_POSITION   = 2'd1,
    REG_MOVE_DURATION  = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  localparam int          CORDIC_W    = 34;
  localparam int          ATAN_LEN    = 24;
  localparam logic [31:0] PI_Q30      = 32'hC90F_DAA2;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD_3B6A;
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] DUR_RESET   = 32'h0001_0000;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Saturate a sign and magnitude pair to a signed 32-bit value.
  function automatic logic [31:0] sat_signed(input logic neg, input logic [50:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 51'h8000_0000) res = 32'h8000_0000;
      else                      res = 32'd0 - mag[31:0];
    end else begin
      if (mag >= 51'h7FFF_FFFF) res = 32'h7FFF_FFFF;
      else                      res = mag[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module cpt_div #(
  parameter int QBITS = 32,
  parameter int PW    = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_vld,
  input  wire logic [31:0]      in_hi,
  input  wire logic [QBITS-1:0] in_lo,
  input  wire logic [31:0]      in_d,
  input  wire logic [PW-1:0]    in_pay,
  output logic                  out_vld,
  output logic [QBITS-1:0]      out_q,
  output logic                  out_ovf,
  output logic [PW-1:0]         out_pay
);

  logic             vld [QBITS];
  logic [31:0]      rem [QBITS];
  logic [QBITS-1:0] lq  [QBITS];
  logic             ovf [QBITS];
  logic [PW-1:0]    pay [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic             vld_prev;
    logic [31:0]      rem_prev;
    logic [QBITS-1:0] lq_prev;
    logic             ovf_prev;
    logic [PW-1:0]    pay_prev;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             qbit;

    if (k == 0) begin : g_first
      assign vld_prev = in_vld;
      assign rem_prev = in_hi;
      assign lq_prev  = in_lo;
      assign ovf_prev = (in_hi >= in_d);
      assign pay_prev = in_pay;
    end else begin : g_next
      assign vld_prev = vld[k-1];
      assign rem_prev = rem[k-1];
      assign lq_prev  = lq[k-1];
      assign ovf_prev = ovf[k-1];
      assign pay_prev = pay[k-1];
    end

    assign trial = {rem_prev, lq_prev[QBITS-1]};
    assign diff  = trial - {1'b0, in_d};
    assign qbit  = ~diff[32];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_prev;
      end
      rem[k] <= qbit ? diff[31:0] : trial[31:0];
      lq[k]  <= {lq_prev[QBITS-2:0], qbit};
      ovf[k] <= ovf_prev;
      pay[k] <= pay_prev;
    end
  end

  assign out_vld = vld[QBITS-1];
  assign out_q   = lq[QBITS-1];
  assign out_ovf = ovf[QBITS-1];
  assign out_pay = pay[QBITS-1];

endmodule
`default_nettype wire

>>> design/cpt_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q4.30.
`default_nettype none
module cpt_cordic #(
  parameter int ITER = 16,
  parameter int PW   = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_vld,
  input  wire logic signed [cpt_pkg::CORDIC_W-1:0] in_z,
  input  wire logic [PW-1:0]                      in_pay,
  output logic                                    out_vld,
  output logic signed [cpt_pkg::CORDIC_W-1:0]     out_x,
  output logic signed [cpt_pkg::CORDIC_W-1:0]     out_y,
  output logic [PW-1:0]                           out_pay
);
  import cpt_pkg::*;

  logic                       vld [ITER];
  logic signed [CORDIC_W-1:0] xr  [ITER];
  logic signed [CORDIC_W-1:0] yr  [ITER];
  logic signed [CORDIC_W-1:0] zr  [ITER];
  logic [PW-1:0]              pay [ITER];

  for (genvar k = 0; k < ITER; k++) begin : g_stage
    logic                       vld_prev;
    logic signed [CORDIC_W-1:0] x_prev;
    logic signed [CORDIC_W-1:0] y_prev;
    logic signed [CORDIC_W-1:0] z_prev;
    logic [PW-1:0]              pay_prev;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] ang;

    if (k == 0) begin : g_first
      assign vld_prev = in_vld;
      assign x_prev   = $signed({{(CORDIC_W-32){1'b0}}, CORDIC_GAIN});
      assign y_prev   = '0;
      assign z_prev   = in_z;
      assign pay_prev = in_pay;
    end else begin : g_next
      assign vld_prev = vld[k-1];
      assign x_prev   = xr[k-1];
      assign y_prev   = yr[k-1];
      assign z_prev   = zr[k-1];
      assign pay_prev = pay[k-1];
    end

    assign xs  = x_prev >>> k;
    assign ys  = y_prev >>> k;
    assign ang = $signed({{(CORDIC_W-32){1'b0}}, ATAN_Q30[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_prev;
      end
      if (!z_prev[CORDIC_W-1]) begin
        xr[k] <= x_prev - ys;
        yr[k] <= y_prev + xs;
        zr[k] <= z_prev - ang;
      end else begin
        xr[k] <= x_prev + ys;
        yr[k] <= y_prev - xs;
        zr[k] <= z_prev + ang;
      end
      pay[k] <= pay_prev;
    end
  end

  assign out_vld = vld[ITER-1];
  assign out_x   = xr[ITER-1];
  assign out_y   = yr[ITER-1];
  assign out_pay = pay[ITER-1];

endmodule
`default_nettype wire

>>> design/cosine_profile_trajectory.sv
// Top level of the half-cosine motion profile generator.
// Throughput: one item per cycle; busy stays low, so an item may follow every cycle.
// Most depth is in the phase divider, the CORDIC, two rate dividers and u_acc2_div.
// Reset clears all valid bits and returns the registers to start 0, end 0, duration 1 s.
`default_nettype none
module cosine_profile_trajectory #(
  parameter int PHASE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] elapsed_time,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             result_valid,
  output logic [31:0]      position,
  output logic [31:0]      velocity,
  output logic [31:0]      acceleration,
  output logic             move_done
);
  import cpt_pkg::*;

  localparam int PB    = PHASE_BITS;
  localparam int QW    = PB + 1;
  localparam int ZW    = PB + 32;
  localparam int NBITS = 50;
  localparam int LAT   = PHASE_BITS + TRIG_ITERATIONS + 91;
  localparam logic [QW-1:0] FULL = QW'(1) << PB;
  localparam logic [QW-1:0] HALF = QW'(1) << (PB - 1);

  logic [31:0] start_position;
  logic [31:0] end_position;
  logic [31:0] move_duration;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      end_position   <= '0;
      move_duration  <= DUR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_POSITION: start_position <= cfg_data;
        REG_END_POSITION:   end_position   <= cfg_data;
        REG_MOVE_DURATION:  move_duration  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [32:0] delta;
  logic [31:0]        dmag;
  logic               dneg;

  assign delta = $signed({end_position[31], end_position})
               - $signed({start_position[31], start_position});
  assign dneg  = delta[32];
  assign dmag  = dneg ? 32'(-delta) : delta[31:0];

  // phase divider
  logic          accept;
  logic          done_in;
  logic          d1_vld;
  logic [QW-1:0] d1_q;
  logic          d1_ovf;
  logic          d1_done;

  assign accept  = start && !busy;
  assign done_in = (move_duration == 32'd0) || (elapsed_time > move_duration);

  cpt_div #(.QBITS(QW), .PW(1)) u_phase_div (
    .clk(clk), .rst(rst),
    .in_vld(accept),
    .in_hi({1'b0, elapsed_time[31:1]}),
    .in_lo({elapsed_time[0], {PB{1'b0}}}),
    .in_d(move_duration),
    .in_pay(done_in),
    .out_vld(d1_vld), .out_q(d1_q), .out_ovf(d1_ovf), .out_pay(d1_done)
  );

  // fold phase into first quarter and scale to an angle
  logic                       za_vld;
  logic signed [CORDIC_W-1:0] za_z;
  logic [1:0]                 za_pay;
  logic [PB-1:0]              fold;
  logic                       flip;
  logic [ZW:0]                zsum;

  assign flip = (d1_q > HALF);
  assign fold = flip ? PB'(FULL - d1_q) : PB'(d1_q);
  assign zsum = (ZW + 1)'(fold) * (ZW + 1)'(PI_Q30) + (ZW + 1)'(HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      za_vld <= 1'b0;
    end else begin
      za_vld <= d1_vld;
    end
    za_z   <= $signed(CORDIC_W'(zsum >> PB));
    za_pay <= {flip, d1_done};
  end

  logic                       cr_vld;
  logic signed [CORDIC_W-1:0] cr_x;
  logic signed [CORDIC_W-1:0] cr_y;
  logic [1:0]                 cr_pay;

  cpt_cordic #(.ITER(TRIG_ITERATIONS), .PW(2)) u_cordic (
    .clk(clk), .rst(rst),
    .in_vld(za_vld), .in_z(za_z), .in_pay(za_pay),
    .out_vld(cr_vld), .out_x(cr_x), .out_y(cr_y), .out_pay(cr_pay)
  );

  // clamp to the unit range
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] one_s;
  logic signed [31:0]         cl_c;
  logic signed [31:0]         cl_s;
  logic                       cl_vld;
  logic                       cl_done;

  assign one_s = $signed({{(CORDIC_W-32){1'b0}}, Q30_ONE});
  assign cx    = cr_pay[1] ? -cr_x : cr_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_vld <= 1'b0;
    end else begin
      cl_vld <= cr_vld;
    end
    if (cx > one_s)       cl_c <= $signed(Q30_ONE);
    else if (cx < -one_s) cl_c <= -$signed(Q30_ONE);
    else                  cl_c <= 32'(cx);
    if (cr_y > one_s)       cl_s <= $signed(Q30_ONE);
    else if (cr_y < -one_s) cl_s <= -$signed(Q30_ONE);
    else                    cl_s <= 32'(cr_y);
    cl_done <= cr_pay[0];
  end

  // first products
  logic               m1_vld;
  logic signed [65:0] m1_pos;
  logic [62:0]        m1_ps;
  logic [62:0]        m1_pc;
  logic               m1_vneg;
  logic               m1_aneg;
  logic               m1_done;
  logic [31:0]        omc;
  logic [30:0]        abs_s;
  logic [30:0]        abs_c;

  assign omc   = 32'($signed({1'b0, Q30_ONE}) - $signed({cl_c[31], cl_c}));
  assign abs_s = cl_s[31] ? 31'(-cl_s) : cl_s[30:0];
  assign abs_c = cl_c[31] ? 31'(-cl_c) : cl_c[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= cl_vld;
    end
    m1_pos  <= delta * $signed({1'b0, omc});
    m1_ps   <= dmag * abs_s;
    m1_pc   <= dmag * abs_c;
    m1_vneg <= dneg ^ cl_s[31];
    m1_aneg <= dneg ^ cl_c[31];
    m1_done <= cl_done;
  end

  // position and split products by pi
  logic               m2_vld;
  logic [31:0]        m2_pos;
  logic [55:0]        m2_sl;
  logic [55:0]        m2_sh;
  logic [55:0]        m2_cl;
  logic [55:0]        m2_ch;
  logic               m2_vneg;
  logic               m2_aneg;
  logic               m2_done;
  logic signed [34:0] pos_wide;
  logic [47:0]        gs;
  logic [47:0]        gc;

  assign pos_wide = $signed({{3{start_position[31]}}, start_position}) + 35'(m1_pos >>> 31);
  assign gs = m1_ps[62:15];
  assign gc = m1_pc[62:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else begin
      m2_vld <= m1_vld;
    end
    if (pos_wide > 35'sh0_7FFF_FFFF)       m2_pos <= 32'h7FFF_FFFF;
    else if (pos_wide < -35'sh0_8000_0000) m2_pos <= 32'h8000_0000;
    else                                   m2_pos <= pos_wide[31:0];
    m2_sl   <= gs[23:0] * PI_Q30;
    m2_sh   <= gs[47:24] * PI_Q30;
    m2_cl   <= gc[23:0] * PI_Q30;
    m2_ch   <= gc[47:24] * PI_Q30;
    m2_vneg <= m1_vneg;
    m2_aneg <= m1_aneg;
    m2_done <= m1_done;
  end

  // sum the halves
  logic             m3_vld;
  logic [NBITS-1:0] m3_ns;
  logic [NBITS-1:0] m3_nc;
  logic [34:0]      m3_pay;
  logic [79:0]      sum_s;
  logic [79:0]      sum_c;

  assign sum_s = {24'd0, m2_sl} + {m2_sh, 24'd0};
  assign sum_c = {24'd0, m2_cl} + {m2_ch, 24'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else begin
      m3_vld <= m2_vld;
    end
    m3_ns  <= sum_s[79:30];
    m3_nc  <= sum_c[79:30];
    m3_pay <= {m2_pos, m2_vneg, m2_aneg, m2_done};
  end

  // rate dividers
  logic             dv_vld;
  logic [NBITS-1:0] dv_q;
  logic             dv_ovf;
  logic [34:0]      dv_pay;
  logic             dm_vld;
  logic [NBITS-1:0] dm_q;
  logic             dm_ovf;
  logic             dm_pay;

  cpt_div #(.QBITS(NBITS), .PW(35)) u_vel_div (
    .clk(clk), .rst(rst),
    .in_vld(m3_vld), .in_hi(32'd0), .in_lo(m3_ns), .in_d(move_duration), .in_pay(m3_pay),
    .out_vld(dv_vld), .out_q(dv_q), .out_ovf(dv_ovf), .out_pay(dv_pay)
  );

  cpt_div #(.QBITS(NBITS), .PW(1)) u_acc_div (
    .clk(clk), .rst(rst),
    .in_vld(m3_vld), .in_hi(32'd0), .in_lo(m3_nc), .in_d(move_duration),
    .in_pay(m3_pay[1]),
    .out_vld(dm_vld), .out_q(dm_q), .out_ovf(dm_ovf), .out_pay(dm_pay)
  );

  // second scaling of acceleration
  logic        m4_vld;
  logic [56:0] m4_al;
  logic [56:0] m4_ah;
  logic [65:0] m4_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_vld <= 1'b0;
    end else begin
      m4_vld <= dv_vld;
    end
    m4_al  <= dm_q[24:0] * PI_Q30;
    m4_ah  <= dm_q[49:25] * PI_Q30;
    m4_pay <= {dv_pay[34:3], sat_signed(dv_pay[2], {1'b0, dv_q}), dm_pay, dv_pay[0]};
  end

  logic        m5_vld;
  logic [51:0] m5_na;
  logic [65:0] m5_pay;
  logic [81:0] sum_a;

  assign sum_a = {25'd0, m4_al} + {m4_ah, 25'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_vld <= 1'b0;
    end else begin
      m5_vld <= m4_vld;
    end
    m5_na  <= sum_a[81:30];
    m5_pay <= m4_pay;
  end

  logic        da_vld;
  logic [31:0] da_q;
  logic        da_ovf;
  logic [65:0] da_pay;

  cpt_div #(.QBITS(32), .PW(66)) u_acc2_div (
    .clk(clk), .rst(rst),
    .in_vld(m5_vld), .in_hi({12'd0, m5_na[51:32]}), .in_lo(m5_na[31:0]),
    .in_d(move_duration), .in_pay(m5_pay),
    .out_vld(da_vld), .out_q(da_q), .out_ovf(da_ovf), .out_pay(da_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= da_vld;
    end
    if (da_pay[0]) begin
      position     <= end_position;
      velocity     <= '0;
      acceleration <= '0;
      move_done    <= 1'b1;
    end else begin
      position     <= da_pay[65:34];
      velocity     <= da_pay[33:2];
      acceleration <= sat_signed(da_pay[1], {da_ovf, 18'd0, da_q});
      move_done    <= 1'b0;
    end
  end

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && move_done |-> velocity == 32'd0 && acceleration == 32'd0)
    else $error("finished move gives nonzero rate");

  a_dur_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_MOVE_DURATION |=> move_duration == $past(cfg_data))
    else $error("duration write lost");

  a_late_done: assert property (@(posedge clk) disable iff (rst)
    accept && done_in |-> ##LAT result_valid && move_done)
    else $error("late item not flagged done");

  a_early_live: assert property (@(posedge clk) disable iff (rst)
    accept && !done_in |-> ##LAT result_valid && !move_done)
    else $error("item within move lost or flagged done");

  a_div_ovf: assert property (@(posedge clk) disable iff (rst)
    d1_vld && !d1_done |-> !d1_ovf)
    else $error("phase divider overflow");

  a_rate_ovf: assert property (@(posedge clk) disable iff (rst)
    dv_vld && !dv_pay[0] |-> !dv_ovf && !dm_ovf)
    else $error("rate divider overflow");

endmodule
`default_nettype wire
